[design/lpst_pkg.sv]
package lpst_pkg;

	// Field widths of one request beat and one response beat
	localparam int OP_W     = 3;
	localparam int KEY_W    = 32;
	localparam int HASH_W   = 32;
	localparam int SIDX_W   = 8;
	localparam int VAL_W    = 64;
	localparam int STATUS_W = 3;

	// Request tdata layout, lowest bit first
	localparam int KEY_LSB    = 0;
	localparam int HASH_LSB   = KEY_LSB + KEY_W;
	localparam int SIDX_LSB   = HASH_LSB + HASH_W;
	localparam int VAL_LSB    = SIDX_LSB + SIDX_W;
	localparam int IN_DATA_W  = ((VAL_LSB + VAL_W + 7) / 8) * 8;

	// Response tdata layout, lowest bit first
	localparam int RSP_FIELDS_W = STATUS_W + SIDX_W + VAL_W;
	localparam int OUT_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_PAD_W    = OUT_DATA_W - RSP_FIELDS_W;

	typedef enum logic [OP_W-1:0] {
		OP_RESOLVE    = 3'd0,
		OP_DEFINE     = 3'd1,
		OP_READ_SLOT  = 3'd2,
		OP_WRITE_SLOT = 3'd3,
		OP_READ_KEY   = 3'd4,
		OP_WRITE_KEY  = 3'd5
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK        = 3'd0,
		STS_NOT_FOUND = 3'd1,
		STS_EMPTY     = 3'd2,
		STS_RANGE     = 3'd3,
		STS_FULL      = 3'd4
	} status_t;

	// Sequencer states, one-hot
	typedef enum logic [5:0] {
		ST_CLEAR  = 6'b000001,
		ST_IDLE   = 6'b000010,
		ST_PROBE  = 6'b000100,
		ST_SLOT   = 6'b001000,
		ST_VCHECK = 6'b010000,
		ST_DONE   = 6'b100000
	} state_t;

endpackage

[design/linear_probe_slot_table_top.sv]
// Sequence: a key op reads one entry per probe step (one entry-memory read per cycle) until it
// stops on a hit or a free entry; a slot op goes straight to its range check; a value read (read
// slot, read by key) adds a step that checks the value memory.
// Next request is taken the cycle after the response is loaded; it waits while m_tready is low.
// Reset (arst_n low, async): count and occupancy are cleared; the entry memory is swept through
// every entry after reset, with s_tready low during the sweep.
module linear_probe_slot_table_top #(
	parameter int TABLE_ENTRIES = 256,
	parameter int KEY_BITS      = 32,
	parameter int VALUE_BITS    = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// name_key[31:0], name_hash[63:32], slot_index[71:64], value_in[135:72]
	input  logic [lpst_pkg::IN_DATA_W-1:0]   s_tdata,
	// operation[2:0]
	input  logic [lpst_pkg::OP_W-1:0]        s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// status[2:0], slot_out[10:3], value_out[74:11], zero pad above
	output logic [lpst_pkg::OUT_DATA_W-1:0]  m_tdata
);

	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int KS    = (KEY_BITS < lpst_pkg::KEY_W) ? KEY_BITS : lpst_pkg::KEY_W;
	localparam int VS    = VALUE_BITS;
	localparam int ENT_W = 1 + KS + IDX_W;
	localparam int SW    = lpst_pkg::SIDX_W;
	// Most keys allowed before load would pass three quarters
	localparam logic [IDX_W-1:0] MAX_DEF  = IDX_W'(3 * TABLE_ENTRIES / 4);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

	// Memories: probe entries {occupied, key, slot} and slot values {valid, value}
	logic [ENT_W-1:0] ent_mem [TABLE_ENTRIES];
	logic [VS:0]      val_mem [TABLE_ENTRIES];

	lpst_pkg::state_t  state_q;
	logic [IDX_W-1:0]  clr_q;
	logic [IDX_W-1:0]  count_q;
	logic              m_tvalid_q;
	logic [lpst_pkg::OUT_DATA_W-1:0] m_tdata_q;

	lpst_pkg::op_t     op_q;
	logic [KS-1:0]     key_q;
	logic [IDX_W-1:0]  idx_q;
	logic [SW-1:0]     sidx_q;
	logic [VS-1:0]     value_q;
	lpst_pkg::status_t res_status_q;
	logic [SW-1:0]     res_slot_q;
	logic [VS-1:0]     res_value_q;

	logic [ENT_W-1:0]  ent_rd_q;
	logic [VS:0]       val_rd_q;

	// Request decode
	lpst_pkg::op_t     in_op;
	logic [KS-1:0]     in_key;
	logic [IDX_W-1:0]  in_idx;
	logic [SW-1:0]     in_sidx;
	logic [VS-1:0]     in_val;
	logic              accept;

	assign in_op   = lpst_pkg::op_t'(s_tuser);
	assign in_key  = s_tdata[lpst_pkg::KEY_LSB +: KS];
	assign in_idx  = s_tdata[lpst_pkg::HASH_LSB +: IDX_W];
	assign in_sidx = s_tdata[lpst_pkg::SIDX_LSB +: SW];
	assign in_val  = s_tdata[lpst_pkg::VAL_LSB +: VS];
	assign s_tready = (state_q == lpst_pkg::ST_IDLE);
	assign accept  = s_tvalid && s_tready;

	// Probe entry fields and decisions
	logic              rd_occ;
	logic [KS-1:0]     rd_key;
	logic [IDX_W-1:0]  rd_slot;
	logic              probe_hit;
	logic              probe_stop;
	logic              is_full;
	logic              op_creates;
	logic              create;

	assign rd_occ     = ent_rd_q[ENT_W-1];
	assign rd_key     = ent_rd_q[IDX_W +: KS];
	assign rd_slot    = ent_rd_q[IDX_W-1:0];
	assign probe_hit  = rd_occ && (rd_key == key_q);
	assign probe_stop = !rd_occ || probe_hit;
	assign is_full    = (count_q >= MAX_DEF);
	assign op_creates = (op_q == lpst_pkg::OP_DEFINE) || (op_q == lpst_pkg::OP_WRITE_KEY);
	assign create     = (state_q == lpst_pkg::ST_PROBE) && !rd_occ && op_creates && !is_full;

	// Width adapters between table index and the 8-bit slot fields
	logic [IDX_W+SW-1:0] sidx_ext;
	logic [IDX_W+SW-1:0] cnt_ext;
	logic [IDX_W+SW-1:0] rdslot_ext;
	logic [IDX_W-1:0]    sidx_idx;
	logic                sidx_in_range;
	logic [SW-1:0]       rd_slot8;
	logic [SW-1:0]       count8;

	assign sidx_ext      = {{IDX_W{1'b0}}, sidx_q};
	assign cnt_ext       = {{SW{1'b0}}, count_q};
	assign rdslot_ext    = {{SW{1'b0}}, rd_slot};
	assign sidx_idx      = sidx_ext[IDX_W-1:0];
	assign sidx_in_range = (sidx_ext < cnt_ext);
	assign rd_slot8      = rdslot_ext[SW-1:0];
	assign count8        = cnt_ext[SW-1:0];

	// Memory port control
	logic              ent_we;
	logic [IDX_W-1:0]  ent_waddr;
	logic [ENT_W-1:0]  ent_wdata;
	logic [IDX_W-1:0]  ent_raddr;
	logic              val_we;
	logic [IDX_W-1:0]  val_waddr;
	logic [VS:0]       val_wdata;
	logic [IDX_W-1:0]  val_raddr;

	always_comb begin
		ent_we    = (state_q == lpst_pkg::ST_CLEAR) || create;
		ent_waddr = (state_q == lpst_pkg::ST_CLEAR) ? clr_q : idx_q;
		ent_wdata = (state_q == lpst_pkg::ST_CLEAR) ? '0 : {1'b1, key_q, count_q};
		// First probe read goes out with the request beat
		ent_raddr = (state_q == lpst_pkg::ST_IDLE) ? in_idx : idx_q + IDX_W'(1);

		val_we    = 1'b0;
		val_waddr = sidx_idx;
		val_wdata = {1'b1, value_q};
		val_raddr = (state_q == lpst_pkg::ST_PROBE) ? rd_slot : sidx_idx;
		if (create) begin
			// New slot: value valid only when the same op writes it
			val_we    = 1'b1;
			val_waddr = count_q;
			val_wdata = {(op_q == lpst_pkg::OP_WRITE_KEY), value_q};
		end else if ((state_q == lpst_pkg::ST_PROBE) && probe_hit &&
				(op_q == lpst_pkg::OP_WRITE_KEY)) begin
			val_we    = 1'b1;
			val_waddr = rd_slot;
		end else if ((state_q == lpst_pkg::ST_SLOT) && sidx_in_range &&
				(op_q == lpst_pkg::OP_WRITE_SLOT)) begin
			val_we    = 1'b1;
		end
	end

	// Entry memory: one write, one registered read per cycle
	always_ff @(posedge clk) begin
		if (ent_we) begin
			ent_mem[ent_waddr] <= ent_wdata;
		end
		ent_rd_q <= ent_mem[ent_raddr];
	end

	// Value memory: one write, one registered read per cycle
	always_ff @(posedge clk) begin
		if (val_we) begin
			val_mem[val_waddr] <= val_wdata;
		end
		val_rd_q <= val_mem[val_raddr];
	end

	// Sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= lpst_pkg::ST_CLEAR;
			clr_q      <= '0;
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			// Drop a taken beat unless the next one loads in the same cycle
			if (m_tvalid_q && m_tready && (state_q != lpst_pkg::ST_DONE)) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				lpst_pkg::ST_CLEAR: begin
					clr_q <= clr_q + IDX_W'(1);
					if (clr_q == LAST_IDX) begin
						state_q <= lpst_pkg::ST_IDLE;
					end
				end
				lpst_pkg::ST_IDLE: begin
					if (s_tvalid) begin
						unique case (in_op) inside
							lpst_pkg::OP_RESOLVE, lpst_pkg::OP_DEFINE,
							lpst_pkg::OP_READ_KEY, lpst_pkg::OP_WRITE_KEY: begin
								state_q <= lpst_pkg::ST_PROBE;
							end
							lpst_pkg::OP_READ_SLOT, lpst_pkg::OP_WRITE_SLOT: begin
								state_q <= lpst_pkg::ST_SLOT;
							end
							default: begin
								state_q <= lpst_pkg::ST_DONE;
							end
						endcase
					end
				end
				lpst_pkg::ST_PROBE: begin
					if (probe_stop) begin
						if (create) begin
							count_q <= count_q + IDX_W'(1);
						end
						if (probe_hit && (op_q == lpst_pkg::OP_READ_KEY)) begin
							state_q <= lpst_pkg::ST_VCHECK;
						end else begin
							state_q <= lpst_pkg::ST_DONE;
						end
					end
				end
				lpst_pkg::ST_SLOT: begin
					if ((op_q == lpst_pkg::OP_READ_SLOT) && sidx_in_range) begin
						state_q <= lpst_pkg::ST_VCHECK;
					end else begin
						state_q <= lpst_pkg::ST_DONE;
					end
				end
				lpst_pkg::ST_VCHECK: begin
					state_q <= lpst_pkg::ST_DONE;
				end
				lpst_pkg::ST_DONE: begin
					// Response register free or draining this cycle
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						state_q    <= lpst_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= lpst_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// Response value, zero-extended to the port field
	logic [VS+lpst_pkg::VAL_W-1:0] res_value_ext;
	assign res_value_ext = {{lpst_pkg::VAL_W{1'b0}}, res_value_q};

	// Request payload and result registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			lpst_pkg::ST_IDLE: begin
				if (accept) begin
					op_q         <= in_op;
					key_q        <= in_key;
					idx_q        <= in_idx;
					sidx_q       <= in_sidx;
					value_q      <= in_val;
					res_status_q <= lpst_pkg::STS_OK;
					res_slot_q   <= '0;
					res_value_q  <= '0;
				end
			end
			lpst_pkg::ST_PROBE: begin
				if (!probe_stop) begin
					idx_q <= idx_q + IDX_W'(1);
				end else if (probe_hit) begin
					res_slot_q <= rd_slot8;
				end else if (!op_creates) begin
					res_status_q <= lpst_pkg::STS_NOT_FOUND;
				end else if (is_full) begin
					res_status_q <= lpst_pkg::STS_FULL;
				end else begin
					res_slot_q <= count8;
				end
			end
			lpst_pkg::ST_SLOT: begin
				res_slot_q <= sidx_q;
				if (!sidx_in_range) begin
					res_status_q <= lpst_pkg::STS_RANGE;
				end
			end
			lpst_pkg::ST_VCHECK: begin
				if (val_rd_q[VS]) begin
					res_value_q <= val_rd_q[VS-1:0];
				end else begin
					res_status_q <= lpst_pkg::STS_EMPTY;
				end
			end
			lpst_pkg::ST_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					m_tdata_q <= {{lpst_pkg::OUT_PAD_W{1'b0}},
						res_value_ext[lpst_pkg::VAL_W-1:0], res_slot_q, res_status_q};
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

`ifndef SYNTH
	// Load never passes three quarters of the table
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= MAX_DEF)
		else $error("defined count above load limit");

	// Each new key takes exactly the next slot number
	a_create_inc: assert property (@(posedge clk) disable iff (!arst_n)
		create |=> (count_q == $past(count_q) + IDX_W'(1)))
		else $error("defined count did not advance on create");

	// One request in flight at a time
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("request taken while another is in flight");

	// No response while the entry sweep runs
	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lpst_pkg::ST_CLEAR) |-> !m_tvalid_q)
		else $error("response during entry sweep");
`endif

endmodule
